// ===== rtl/asc_pkg.sv =====
// ----------------------------------------------------------------------------
// asc_pkg: shared types, codes and limit tables for the stick/trigger clamp
// ----------------------------------------------------------------------------
package asc_pkg;

    localparam logic [2:0] REG_STICK_SHAPE    = 3'd0;
    localparam logic [2:0] REG_STICK_REGION   = 3'd1;
    localparam logic [2:0] REG_STICK_ENABLE   = 3'd2;
    localparam logic [2:0] REG_TRIGGER_ENABLE = 3'd3;
    localparam logic [2:0] REG_TRIGGER_REGION = 3'd4;

    localparam logic SHAPE_OCTAGON = 1'b0;
    localparam logic SHAPE_CIRCLE  = 1'b1;

    // Lane pipeline shape: square root steps and divider widths.
    localparam int SQ_STEPS  = 8;
    localparam int DIV_NUM_W = 20;
    localparam int DIV_DEN_W = 14;
    // Two front stages, the square root, the numerator stage and the divider.
    localparam int PIPE_LAT  = 3 + SQ_STEPS + DIV_NUM_W;

    typedef struct packed {
        logic [3:0] dead;
        logic [6:0] axis;
        logic [6:0] diag;
        logic [6:0] radius;
    } t_limits;

    // Per-lane settings handed from the top to a stick lane.
    typedef struct packed {
        logic    enable;
        logic    shape;
        t_limits lim;
    } t_lane_cfg;

    function automatic t_limits stick_limits(input logic [1:0] region, input logic sub);
        t_limits l;
        unique case (region)
            2'd0:    l = sub ? '{4'd15, 7'd59, 7'd31, 7'd44} : '{4'd15, 7'd72, 7'd40, 7'd56};
            2'd1:    l = sub ? '{4'd15, 7'd59, 7'd37, 7'd50} : '{4'd15, 7'd72, 7'd47, 7'd62};
            default: l = sub ? '{4'd0, 7'd74, 7'd52, 7'd68}  : '{4'd0, 7'd87, 7'd62, 7'd80};
        endcase
        return l;
    endfunction

    localparam logic [7:0] TRIG_MAX = 8'd180;

    function automatic logic [7:0] trig_dead(input logic region);
        return region ? 8'd0 : 8'd30;
    endfunction

endpackage

// ===== rtl/asc_div.sv =====
// ----------------------------------------------------------------------------
// asc_div: pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
// Unsigned numerator / denominator. Each stage registers the partial
// remainder; the valid chain rides alongside with the sideband payload.
module asc_div
    import asc_pkg::*;
#(
    parameter int NUM_W = 14,
    parameter int DEN_W = 14,
    parameter int SB_W  = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [SB_W-1:0]  i_sb,
    output logic             o_valid,
    output logic [NUM_W-1:0] o_quot,
    output logic [SB_W-1:0]  o_sb
);
    logic               r_vld [NUM_W+1];
    logic [DEN_W:0]     r_rem [NUM_W+1];
    logic [NUM_W-1:0]   r_num [NUM_W+1];
    logic [DEN_W-1:0]   r_den [NUM_W+1];
    logic [SB_W-1:0]    r_sb  [NUM_W+1];

    always_comb begin
        r_rem[0] = '0;
        r_num[0] = i_num;
        r_den[0] = i_den;
        r_sb[0]  = i_sb;
        r_vld[0] = i_valid;
    end

    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        logic [DEN_W+1:0] n_trial;
        logic [DEN_W:0]   n_rem;
        logic [NUM_W-1:0] n_num;
        always_comb begin
            n_trial = {r_rem[s], r_num[s][NUM_W-1]} - {2'b00, r_den[s]};
            if (!n_trial[DEN_W+1]) begin
                n_rem = n_trial[DEN_W:0];
            end else begin
                n_rem = {r_rem[s][DEN_W-1:0], r_num[s][NUM_W-1]};
            end
            n_num = {r_num[s][NUM_W-2:0], ~n_trial[DEN_W+1]};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (i_adv) begin
                r_vld[s+1] <= r_vld[s];
            end
            if (i_adv) begin
                r_rem[s+1] <= n_rem;
                r_num[s+1] <= n_num;
                r_den[s+1] <= r_den[s];
                r_sb[s+1]  <= r_sb[s];
            end
        end
    end

    assign o_valid = r_vld[NUM_W];
    assign o_quot  = r_num[NUM_W];
    assign o_sb    = r_sb[NUM_W];
endmodule

// ===== rtl/asc_lane.sv =====
// ----------------------------------------------------------------------------
// asc_lane: dead zone and octagon/circle clamp for one stick
// ----------------------------------------------------------------------------
// Stage 1 strips the dead zone, stage 2 forms the octagon or circle test terms.
// The square root then runs one result bit per registered stage, the next
// stage forms the scaled numerators, and two dividers produce the scaled axes.
module asc_lane
    import asc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_valid,
    input  t_lane_cfg        i_cfg,
    input  logic             i_bypass,
    input  logic signed [7:0] i_x,
    input  logic signed [7:0] i_y,
    output logic             o_valid,
    output logic signed [7:0] o_x,
    output logic signed [7:0] o_y
);
    // Stage 1: magnitudes with dead zone removed.
    logic [7:0]  n_ax, n_ay, n_mx, n_my;
    logic        n_nx, n_ny;
    always_comb begin
        n_nx = i_x[7];
        n_ny = i_y[7];
        n_ax = n_nx ? 8'(-i_x) : 8'(i_x);
        n_ay = n_ny ? 8'(-i_y) : 8'(i_y);
        n_mx = (n_ax <= {4'd0, i_cfg.lim.dead}) ? 8'd0 : n_ax - {4'd0, i_cfg.lim.dead};
        n_my = (n_ay <= {4'd0, i_cfg.lim.dead}) ? 8'd0 : n_ay - {4'd0, i_cfg.lim.dead};
    end

    logic        r1_vld;
    logic [7:0]  r1_mx, r1_my;
    logic        r1_nx, r1_ny, r1_pass, r1_shape;
    logic signed [7:0] r1_rx, r1_ry;
    t_limits     r1_lim;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (i_adv) begin
            r1_vld <= i_valid;
        end
        if (i_adv) begin
            r1_mx    <= n_mx;
            r1_my    <= n_my;
            r1_nx    <= n_nx;
            r1_ny    <= n_ny;
            r1_pass  <= i_bypass || !i_cfg.enable;
            r1_shape <= i_cfg.shape;
            r1_lim   <= i_cfg.lim;
            r1_rx    <= i_x;
            r1_ry    <= i_y;
        end
    end

    // Stage 2: norm terms.
    logic [14:0] n_d, n_lim;
    logic [15:0] n_sq, n_rr;
    logic [7:0]  n_hi, n_lo;
    always_comb begin
        n_hi  = (r1_my <= r1_mx) ? r1_mx : r1_my;
        n_lo  = (r1_my <= r1_mx) ? r1_my : r1_mx;
        n_d   = 15'(r1_lim.diag * n_hi) + 15'((r1_lim.axis - r1_lim.diag) * n_lo);
        n_sq  = 16'(r1_mx * r1_mx) + 16'(r1_my * r1_my);
        n_lim = 15'(r1_lim.diag * r1_lim.axis);
        n_rr  = 16'(r1_lim.radius * r1_lim.radius);
    end

    logic        r2_vld;
    logic [14:0] r2_d;
    logic [15:0] r2_sq;
    logic        r2_clip;
    logic [7:0]  r2_mx, r2_my;
    logic        r2_nx, r2_ny, r2_pass, r2_shape;
    logic signed [7:0] r2_rx, r2_ry;
    logic [12:0] r2_lim;
    logic [6:0]  r2_rad;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (i_adv) begin
            r2_vld <= r1_vld;
        end
        if (i_adv) begin
            r2_d     <= n_d;
            r2_sq    <= n_sq;
            r2_clip  <= r1_shape ? (n_rr < n_sq) : (n_lim < n_d);
            r2_mx    <= r1_mx;
            r2_my    <= r1_my;
            r2_nx    <= r1_nx;
            r2_ny    <= r1_ny;
            r2_pass  <= r1_pass;
            r2_shape <= r1_shape;
            r2_rx    <= r1_rx;
            r2_ry    <= r1_ry;
            r2_lim   <= n_lim[12:0];
            r2_rad   <= r1_lim.radius;
        end
    end

    // Square root: one result bit per registered stage.
    logic [15:0] r_sv  [SQ_STEPS+1];
    logic [7:0]  r_sr  [SQ_STEPS+1];
    logic        r_svld [SQ_STEPS+1];
    typedef struct packed {
        logic [14:0] d;
        logic        clip;
        logic [7:0]  mx, my;
        logic        nx, ny, pass, shape;
        logic [7:0]  rx, ry;
        logic [12:0] lim;
        logic [6:0]  rad;
    } t_ride;
    t_ride r_ride [SQ_STEPS+1];
    always_comb begin
        r_sv[0]   = r2_sq;
        r_sr[0]   = '0;
        r_svld[0] = r2_vld;
        r_ride[0] = '{r2_d, r2_clip, r2_mx, r2_my, r2_nx, r2_ny, r2_pass, r2_shape,
                      r2_rx, r2_ry, r2_lim, r2_rad};
    end
    for (genvar s = 0; s < SQ_STEPS; s++) begin : g_sqrt
        localparam int B = SQ_STEPS - 1 - s;
        logic [7:0]  n_try;
        logic [15:0] n_t2;
        always_comb begin
            n_try = r_sr[s] | (8'd1 << B);
            n_t2  = n_try * n_try;
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_svld[s+1] <= 1'b0;
            end else if (i_adv) begin
                r_svld[s+1] <= r_svld[s];
            end
            if (i_adv) begin
                r_sv[s+1]   <= r_sv[s];
                r_sr[s+1]   <= (n_t2 <= r_sv[s]) ? n_try : r_sr[s];
                r_ride[s+1] <= r_ride[s];
            end
        end
    end

    // Stage 3: numerators and denominator for the scale.
    t_ride                 w;
    logic [DIV_NUM_W-1:0]  n_nxs, n_nys;
    logic [DIV_DEN_W-1:0]  n_den;
    always_comb begin
        w = r_ride[SQ_STEPS];
        if (w.shape) begin
            n_nxs = DIV_NUM_W'(w.mx * w.rad);
            n_nys = DIV_NUM_W'(w.my * w.rad);
            n_den = {6'd0, r_sr[SQ_STEPS]};
        end else begin
            n_nxs = DIV_NUM_W'(w.lim * w.mx);
            n_nys = DIV_NUM_W'(w.lim * w.my);
            n_den = w.d[13:0];
        end
        if (n_den == '0) begin
            n_den = 14'd1;
        end
    end

    logic                 r3_vld;
    logic [DIV_NUM_W-1:0] r3_nx, r3_ny;
    logic [DIV_DEN_W-1:0] r3_den;
    logic [17:0]          r3_sb;
    logic [15:0]          r3_raw;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (i_adv) begin
            r3_vld <= r_svld[SQ_STEPS];
        end
        if (i_adv) begin
            r3_nx  <= n_nxs;
            r3_ny  <= n_nys;
            r3_den <= n_den;
            r3_sb  <= {w.clip, w.nx, w.ny, w.pass, w.mx[6:0], w.my[6:0]};
            r3_raw <= {w.rx, w.ry};
        end
    end

    logic [DIV_NUM_W-1:0] w_qx, w_qy;
    logic [17:0]          w_sb;
    logic [15:0]          w_raw;
    logic                 w_dvx, w_dvy;

    // Raw axes ride the x divider; clip, sign and pass flags and the magnitudes ride the y divider.
    asc_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W), .SB_W(16)) u_div_x (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_adv  (i_adv),
        .i_valid(r3_vld),
        .i_num  (r3_nx),
        .i_den  (r3_den),
        .i_sb   (r3_raw),
        .o_valid(w_dvx),
        .o_quot (w_qx),
        .o_sb   (w_raw)
    );
    asc_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W), .SB_W(18)) u_div_y (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_adv  (i_adv),
        .i_valid(r3_vld),
        .i_num  (r3_ny),
        .i_den  (r3_den),
        .i_sb   (r3_sb),
        .o_valid(w_dvy),
        .o_quot (w_qy),
        .o_sb   (w_sb)
    );

    assign o_valid = w_dvx && w_dvy;

    // Merge: restore signs, pick pass-through, scaled or unclipped magnitude.
    logic [6:0] n_fx, n_fy;
    always_comb begin
        n_fx = w_sb[17] ? w_qx[6:0] : w_sb[13:7];
        n_fy = w_sb[17] ? w_qy[6:0] : w_sb[6:0];
        if (w_sb[14]) begin
            o_x = w_raw[15:8];
            o_y = w_raw[7:0];
        end else begin
            o_x = w_sb[16] ? -$signed({1'b0, n_fx}) : $signed({1'b0, n_fx});
            o_y = w_sb[15] ? -$signed({1'b0, n_fy}) : $signed({1'b0, n_fy});
        end
    end
endmodule

// ===== rtl/analog_stick_trigger_clamp_top.sv =====
// ----------------------------------------------------------------------------
// analog_stick_trigger_clamp_top: controller sample dead zone and clamp
// ----------------------------------------------------------------------------
// Takes one sample per cycle unless stalled and returns one word per sample
// through two front lane stages, eight square root stages, the numerator
// stage and twenty divider stages; the divider pipelines are the longest part.
// Both sticks run in parallel lanes, triggers ride alongside. A stall on a
// waiting output word freezes the whole pipeline and stalls the input in the
// same cycle.
module analog_stick_trigger_clamp_top
    import asc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_controller_fault,
    input  logic signed [7:0] i_stick_x,
    input  logic signed [7:0] i_stick_y,
    input  logic signed [7:0] i_sub_x,
    input  logic signed [7:0] i_sub_y,
    input  logic [7:0]        i_trigger_left,
    input  logic [7:0]        i_trigger_right,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_index,
    input  logic [1:0]        i_cfg_data,
    output logic              o_valid,
    input  logic              i_stall,
    output logic signed [7:0] o_out_stick_x,
    output logic signed [7:0] o_out_stick_y,
    output logic signed [7:0] o_out_sub_x,
    output logic signed [7:0] o_out_sub_y,
    output logic [7:0]        o_out_trigger_left,
    output logic [7:0]        o_out_trigger_right
);
    logic       r_shape, r_sen, r_ten, r_treg;
    logic [1:0] r_sreg;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shape <= SHAPE_OCTAGON;
            r_sreg  <= 2'd0;
            r_sen   <= 1'b1;
            r_ten   <= 1'b1;
            r_treg  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_STICK_SHAPE:    r_shape <= i_cfg_data[0];
                REG_STICK_REGION:   r_sreg  <= i_cfg_data;
                REG_STICK_ENABLE:   r_sen   <= i_cfg_data[0];
                REG_TRIGGER_ENABLE: r_ten   <= i_cfg_data[0];
                REG_TRIGGER_REGION: r_treg  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Pipeline advances unless the output word is held by a stall.
    logic w_adv;
    assign w_adv   = !(o_valid && i_stall);
    assign o_stall = !w_adv;

    t_lane_cfg w_cfg_m, w_cfg_s;
    assign w_cfg_m = '{r_sen, r_shape, stick_limits(r_sreg, 1'b0)};
    assign w_cfg_s = '{r_sen, r_shape, stick_limits(r_sreg, 1'b1)};

    logic              w_vm, w_vs;
    logic signed [7:0] w_mx, w_my, w_sx, w_sy;

    asc_lane u_main (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(w_adv), .i_valid(i_valid),
        .i_cfg(w_cfg_m), .i_bypass(i_controller_fault), .i_x(i_stick_x), .i_y(i_stick_y),
        .o_valid(w_vm), .o_x(w_mx), .o_y(w_my)
    );
    asc_lane u_sub (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(w_adv), .i_valid(i_valid),
        .i_cfg(w_cfg_s), .i_bypass(i_controller_fault), .i_x(i_sub_x), .i_y(i_sub_y),
        .o_valid(w_vs), .o_x(w_sx), .o_y(w_sy)
    );

    // Trigger clamp, then delay to match the stick lanes.
    logic [7:0] n_tl, n_tr, w_dead;
    always_comb begin
        w_dead = trig_dead(r_treg);
        n_tl = i_trigger_left;
        n_tr = i_trigger_right;
        if (!i_controller_fault && r_ten) begin
            n_tl = (i_trigger_left <= w_dead) ? 8'd0 :
                   ((i_trigger_left > TRIG_MAX) ? TRIG_MAX : i_trigger_left) - w_dead;
            n_tr = (i_trigger_right <= w_dead) ? 8'd0 :
                   ((i_trigger_right > TRIG_MAX) ? TRIG_MAX : i_trigger_right) - w_dead;
        end
    end

    logic [15:0] r_tdly [PIPE_LAT];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_tdly[0] <= {n_tl, n_tr};
            for (int k = 1; k < PIPE_LAT; k++) begin
                r_tdly[k] <= r_tdly[k-1];
            end
        end
    end

    assign o_valid             = w_vm;
    assign o_out_stick_x       = w_mx;
    assign o_out_stick_y       = w_my;
    assign o_out_sub_x         = w_sx;
    assign o_out_sub_y         = w_sy;
    assign o_out_trigger_left  = r_tdly[PIPE_LAT-1][15:8];
    assign o_out_trigger_right = r_tdly[PIPE_LAT-1][7:0];

    a_lanes_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_vm == w_vs) else $error("stick lanes out of step");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_stick_x) && $stable(o_out_trigger_left))
        else $error("held word changed");
endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: stick and trigger clamp check
// ----------------------------------------------------------------------------
// Drives controller samples under random idling on both sides and compares
// every output word with an in-bench integer model of the dead zone and
// octagon/circle clamps, across every value of each register setting.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench
    import asc_pkg::*;
();

    typedef struct {
        logic signed [7:0] sx, sy, cx, cy;
        logic [7:0]        tl, tr;
    } t_word;

    class clamp_scoreboard;
        t_word pending[$];
        int    errors;

        function void note(t_word w);
            pending.push_back(w);
        endfunction

        function void check(t_word w);
            t_word e;
            if (pending.size() == 0) begin
                $error("unexpected output word");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (w.sx !== e.sx) begin
                $error("out_stick_x exp %0d got %0d", e.sx, w.sx); errors++;
            end
            if (w.sy !== e.sy) begin
                $error("out_stick_y exp %0d got %0d", e.sy, w.sy); errors++;
            end
            if (w.cx !== e.cx) begin
                $error("out_sub_x exp %0d got %0d", e.cx, w.cx); errors++;
            end
            if (w.cy !== e.cy) begin
                $error("out_sub_y exp %0d got %0d", e.cy, w.cy); errors++;
            end
            if (w.tl !== e.tl) begin
                $error("out_trigger_left exp %0d got %0d", e.tl, w.tl); errors++;
            end
            if (w.tr !== e.tr) begin
                $error("out_trigger_right exp %0d got %0d", e.tr, w.tr); errors++;
            end
        endfunction
    endclass

    logic              i_clk = 0, i_rst_n = 0, i_valid = 0, i_stall = 0;
    logic              i_controller_fault = 0;
    logic signed [7:0] i_stick_x = 0, i_stick_y = 0, i_sub_x = 0, i_sub_y = 0;
    logic [7:0]        i_trigger_left = 0, i_trigger_right = 0;
    logic              i_cfg_we = 0;
    logic [2:0]        i_cfg_index = 0;
    logic [1:0]        i_cfg_data = 0;
    logic              o_stall, o_valid;
    logic signed [7:0] o_out_stick_x, o_out_stick_y, o_out_sub_x, o_out_sub_y;
    logic [7:0]        o_out_trigger_left, o_out_trigger_right;

    analog_stick_trigger_clamp_top dut (.*);

    always #5 i_clk = ~i_clk;

    clamp_scoreboard sb = new();
    int cfg_shape = 0, cfg_region = 0, cfg_sen = 1, cfg_ten = 1, cfg_treg = 0;
    int send_idle = 0, recv_idle = 0;

    function automatic int isqrt(int v);
        int r = 0;
        while ((r + 1) * (r + 1) <= v) r++;
        return r;
    endfunction

    // Fetch dead, axis, diag, radius for one stick.
    function automatic void stick_lim(int sub, output int dd, ax, dg, rd);
        int r = (cfg_region > 2) ? 2 : cfg_region;
        case (r)
            0: begin dd = 15; ax = sub ? 59 : 72; dg = sub ? 31 : 40; rd = sub ? 44 : 56; end
            1: begin dd = 15; ax = sub ? 59 : 72; dg = sub ? 37 : 47; rd = sub ? 50 : 62; end
            default: begin
                dd = 0; ax = sub ? 74 : 87; dg = sub ? 52 : 62; rd = sub ? 68 : 80;
            end
        endcase
    endfunction

    function automatic void clamp_stick(int sub, inout int x, inout int y);
        int dd, ax, dg, rd, ux, uy, d, lim, sq, len;
        bit nx, ny;
        stick_lim(sub, dd, ax, dg, rd);
        if (cfg_shape == SHAPE_CIRCLE) begin
            x = (x > -dd && x < dd) ? 0 : (x > 0 ? x - dd : x + dd);
            y = (y > -dd && y < dd) ? 0 : (y > 0 ? y - dd : y + dd);
            sq = x * x + y * y;
            if (rd * rd < sq) begin
                len = isqrt(sq);
                x = (x * rd) / len;
                y = (y * rd) / len;
            end
        end else begin
            nx = x < 0; ny = y < 0;
            ux = nx ? -x : x; uy = ny ? -y : y;
            ux = (ux <= dd) ? 0 : ux - dd;
            uy = (uy <= dd) ? 0 : uy - dd;
            if (ux == 0 && uy == 0) begin
                x = 0; y = 0; return;
            end
            d = (uy <= ux) ? dg * ux + (ax - dg) * uy : dg * uy + (ax - dg) * ux;
            lim = dg * ax;
            if (lim < d) begin
                ux = lim * ux / d; uy = lim * uy / d;
            end
            x = nx ? -ux : ux; y = ny ? -uy : uy;
        end
    endfunction

    function automatic int clamp_trig(int t);
        int dd = cfg_treg ? 0 : 30;
        if (t <= dd) return 0;
        if (t > 180) t = 180;
        return t - dd;
    endfunction

    function automatic t_word predict_clamp(bit f, int sx, sy, cx, cy, tl, tr);
        t_word w;
        if (!f) begin
            if (cfg_sen) begin
                clamp_stick(0, sx, sy);
                clamp_stick(1, cx, cy);
            end
            if (cfg_ten) begin
                tl = clamp_trig(tl); tr = clamp_trig(tr);
            end
        end
        w.sx = 8'(sx); w.sy = 8'(sy); w.cx = 8'(cx); w.cy = 8'(cy);
        w.tl = 8'(tl); w.tr = 8'(tr);
        return w;
    endfunction

    task automatic send_sample(bit f, int sx, sy, cx, cy, tl, tr);
        while (send_idle && $urandom_range(99) < send_idle) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_controller_fault <= f;
        i_stick_x <= 8'(sx); i_stick_y <= 8'(sy); i_sub_x <= 8'(cx); i_sub_y <= 8'(cy);
        i_trigger_left <= 8'(tl); i_trigger_right <= 8'(tr);
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note(predict_clamp(f, $signed(8'(sx)), $signed(8'(sy)), $signed(8'(cx)),
                              $signed(8'(cy)), tl & 8'hff, tr & 8'hff));
    endtask

    task automatic send_random;
        int k = $urandom_range(9);
        int a[4];
        foreach (a[j])
            a[j] = (k < 3) ? $signed($urandom_range(40)) - 20
                 : $signed($urandom_range(255)) - 128;
        send_sample($urandom_range(9) == 0, a[0], a[1], a[2], a[3],
                    $urandom_range(255), $urandom_range(255));
    endtask

    // Hold the write enable; the caller drops it after the last write.
    task automatic write_reg(logic [2:0] idx, int val);
        i_cfg_we <= 1; i_cfg_index <= idx; i_cfg_data <= 2'(val);
        @(posedge i_clk);
        case (idx)
            REG_STICK_SHAPE:    cfg_shape = val;
            REG_STICK_REGION:   cfg_region = val;
            REG_STICK_ENABLE:   cfg_sen = val;
            REG_TRIGGER_ENABLE: cfg_ten = val;
            REG_TRIGGER_REGION: cfg_treg = val;
            default: ;
        endcase
    endtask

    task automatic drain;
        i_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // Receiver: random stall, check each accepted word.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check('{o_out_stick_x, o_out_stick_y, o_out_sub_x, o_out_sub_y,
                       o_out_trigger_left, o_out_trigger_right});
        i_stall <= recv_idle && ($urandom_range(99) < recv_idle);
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: extremes, dead zone, fault, diagonals
        send_sample(0, -128, -128, 127, 127, 255, 0);
        send_sample(0, 127, -128, -128, 127, 30, 31);
        send_sample(0, 10, -10, 15, -15, 180, 181);
        send_sample(0, 16, 0, 0, -16, 0, 1);
        send_sample(1, -128, 127, 5, -5, 255, 10);
        send_sample(0, 60, 60, -60, 60, 100, 200);
        send_sample(0, 0, 0, 0, 0, 29, 255);
        for (int ph = 0; ph < 12; ph++) begin
            drain();
            write_reg(REG_STICK_SHAPE, ph % 2);
            write_reg(REG_STICK_REGION, (ph / 2) % 4);
            write_reg(REG_STICK_ENABLE, ph != 5);
            write_reg(REG_TRIGGER_ENABLE, ph != 7);
            write_reg(REG_TRIGGER_REGION, (ph / 3) % 2);
            i_cfg_we <= 0;
            send_idle = (ph < 4) ? 35 : (ph < 8) ? 53 : 0;
            recv_idle = (ph < 4) ? 53 : (ph < 8) ? 35 : 0;
            send_sample(0, -128, -128, 127, -128, 255, 0);
            send_sample(0, 127, 127, -128, 127, 181, 31);
            repeat (150) send_random();
        end
        drain();
        if (sb.errors == 0)
            $display("analog_stick_trigger_clamp_top: match");
        else
            $display("analog_stick_trigger_clamp_top: mismatch");
        $finish;
    end

    initial begin
        #2000000;
        $display("analog_stick_trigger_clamp_top: mismatch");
        $finish;
    end
endmodule
